### src/wrapping_range_arithmetic_macros.svh
// Assertion macros for the wrapping range arithmetic block.
// No dependencies; include by bare file name in the files that assert.
`ifndef WRAPPING_RANGE_ARITHMETIC_MACROS_SVH
`define WRAPPING_RANGE_ARITHMETIC_MACROS_SVH

// Clocked assertion with reset disable and error report.
`define WRA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Shorthand for the usual clk and rst names.
`define WRA_CHECK(label, prop, msg) `WRA_ASSERT(label, clk, rst, prop, msg)

`endif

### src/wra_pkg.sv
// Shared types and codes for the wrapping range arithmetic block.
// No dependencies; imported by the controller, datapath and top level.
package wra_pkg;

  // Request codes; the unused codes read the held value.
  localparam logic [2:0] REQ_ASSIGN = 3'd0;
  localparam logic [2:0] REQ_ADD    = 3'd1;
  localparam logic [2:0] REQ_SUB    = 3'd2;
  localparam logic [2:0] REQ_MUL    = 3'd3;
  localparam logic [2:0] REQ_DIV    = 3'd4;

  // Register index, taken from the word address bit.
  localparam logic REG_MIN_BOUND = 1'b0;
  localparam logic REG_MAX_BOUND = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DIV_FIN,
    ST_MOD_INIT,
    ST_MOD,
    ST_MOD_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_step;
    logic div_fin;
    logic mod_init;
    logic mod_step;
    logic mod_fin;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } status_t;

endpackage

### src/wra_divider.sv
// Bit-serial restoring divider, one quotient bit per step.
// No dependencies; instantiated by the datapath.
module wra_divider #(
  parameter int DVD_WIDTH = 32,
  parameter int DVS_WIDTH = 17
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 step,
  input  logic [DVD_WIDTH-1:0] dividend,
  input  logic [DVS_WIDTH-1:0] divisor,
  output logic [DVD_WIDTH-1:0] quotient,
  output logic [DVS_WIDTH-1:0] remainder
);

  logic [DVS_WIDTH-1:0] dvs;
  logic [DVS_WIDTH:0]   trial;
  logic                 fits;

  // Shift in the next dividend bit and test against the divisor.
  assign trial = {remainder, quotient[DVD_WIDTH-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (load) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (step) begin
      quotient <= {quotient[DVD_WIDTH-2:0], fits};
      if (fits) begin
        remainder <= DVS_WIDTH'(trial - {1'b0, dvs});
      end else begin
        remainder <= trial[DVS_WIDTH-1:0];
      end
    end
  end

endmodule

### src/wra_ctrl.sv
// Sequencing state machine for the wrapping range arithmetic block.
// Depends on wra_pkg for the state, command and status types.
module wra_ctrl #(
  parameter int DATA_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wra_pkg::status_t  status,
  output wra_pkg::cmd_t     cmd
);
  import wra_pkg::*;

  localparam int CW = $clog2(2 * DATA_WIDTH);

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Count divider steps; clear outside the stepping states.
  always_comb begin
    if (state == ST_DIV || state == ST_MOD) begin
      cnt_next = cnt + CW'(1);
    end else begin
      cnt_next = '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = status.need_div ? ST_DIV : ST_MOD_INIT;
      end
      ST_DIV: begin
        if (cnt == CW'(DATA_WIDTH - 1)) state_next = ST_DIV_FIN;
      end
      ST_DIV_FIN:  state_next = ST_MOD_INIT;
      ST_MOD_INIT: state_next = ST_MOD;
      ST_MOD: begin
        if (cnt == CW'(2 * DATA_WIDTH - 1)) state_next = ST_MOD_FIN;
      end
      ST_MOD_FIN: state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC:     cmd.exec     = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_DIV_FIN:  cmd.div_fin  = 1'b1;
      ST_MOD_INIT: cmd.mod_init = 1'b1;
      ST_MOD:      cmd.mod_step = 1'b1;
      ST_MOD_FIN:  cmd.mod_fin  = 1'b1;
      ST_DONE:     cmd.deliver  = status.out_free;
      default:     cmd          = '0;
    endcase
  end

endmodule

### src/wra_dpath.sv
// Datapath: held value, operation unit, shared divider and output register.
// Depends on wra_pkg and wra_divider.
module wra_dpath #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wra_pkg::cmd_t                cmd,
  output wra_pkg::status_t             status,
  input  logic [2:0]                   req_type,
  input  logic signed [DATA_WIDTH-1:0] operand,
  input  logic                         write_back,
  input  logic signed [DATA_WIDTH-1:0] min_bound,
  input  logic signed [DATA_WIDTH-1:0] max_bound,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] result,
  output logic                         zero_divisor
);
  import wra_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int XW = 2 * DATA_WIDTH;
  localparam int VW = DATA_WIDTH + 1;

  logic [2:0]            kind;
  logic signed [W-1:0]   opd;
  logic                  wb;
  logic signed [W-1:0]   lo;
  logic [VW-1:0]         span;
  logic signed [W-1:0]   held;
  logic signed [XW-1:0]  x;
  logic                  zdiv;
  logic                  qneg;
  logic                  dneg;
  logic signed [W-1:0]   res;

  logic signed [W-1:0]   lo_in;
  logic signed [W-1:0]   hi_in;
  logic signed [XW-1:0]  prod;
  logic [W-1:0]          cur_mag;
  logic [W-1:0]          opd_mag;
  logic signed [XW:0]    d_full;
  logic [XW-1:0]         d_mag;
  logic signed [XW-1:0]  q_ext;
  logic [VW-1:0]         m;
  logic                  div_load;
  logic                  div_step;
  logic [XW-1:0]         dividend;
  logic [VW-1:0]         divisor;
  logic [XW-1:0]         quot;
  logic [VW-1:0]         rem;

  assign lo_in   = (min_bound < max_bound) ? min_bound : max_bound;
  assign hi_in   = (min_bound < max_bound) ? max_bound : min_bound;
  assign prod    = held * opd;
  assign cur_mag = held[W-1] ? W'(-held) : W'(held);
  assign opd_mag = opd[W-1] ? W'(-opd) : W'(opd);
  assign d_full  = (XW+1)'(x) - (XW+1)'(lo);
  assign d_mag   = d_full[XW] ? XW'(-d_full) : XW'(d_full);
  assign q_ext   = XW'(quot[W-1:0]);
  assign m       = (dneg && rem != '0) ? VW'(span - rem) : rem;

  // One divider serves the quotient and then the modulo by the span.
  assign div_load = cmd.exec | cmd.mod_init;
  assign div_step = cmd.div_step | cmd.mod_step;
  assign dividend = cmd.mod_init ? d_mag : {cur_mag, {W{1'b0}}};
  assign divisor  = cmd.mod_init ? span : {1'b0, opd_mag};

  wra_divider #(
    .DVD_WIDTH (XW),
    .DVS_WIDTH (VW)
  ) u_div (
    .clk       (clk),
    .load      (div_load),
    .step      (div_step),
    .dividend  (dividend),
    .divisor   (divisor),
    .quotient  (quot),
    .remainder (rem)
  );

  assign status.need_div = (kind == REQ_DIV) && (opd != '0);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind <= req_type;
      opd  <= operand;
      wb   <= write_back;
      lo   <= lo_in;
      span <= VW'(hi_in) - VW'(lo_in) + VW'(1);
    end
    if (cmd.exec) begin
      zdiv <= (kind == REQ_DIV) && (opd == '0);
      qneg <= held[W-1] ^ opd[W-1];
      case (kind)
        REQ_ASSIGN: x <= XW'(opd);
        REQ_ADD:    x <= XW'(held) + XW'(opd);
        REQ_SUB:    x <= XW'(held) - XW'(opd);
        REQ_MUL:    x <= prod;
        REQ_DIV:    x <= '0;
        default:    x <= XW'(held);
      endcase
    end
    if (cmd.div_fin) begin
      x <= qneg ? -q_ext : q_ext;
    end
    if (cmd.mod_init) begin
      dneg <= d_full[XW];
    end
    if (cmd.mod_fin) begin
      res <= lo + W'(m);
    end
    if (cmd.deliver) begin
      result       <= res;
      zero_divisor <= zdiv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.deliver && wb) begin
        held <= res;
      end
      if (cmd.deliver) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/wrapping_range_arithmetic.sv
// Top level of the wrapping range arithmetic block: APB registers and wiring.
// Depends on wra_pkg, wra_ctrl and wra_dpath (and through it wra_divider).
//
// The block holds one signed value and applies assign, add, subtract,
// multiply or truncating divide with the request operand; the exact result
// is wrapped into the inclusive interval between the two bound registers
// (used swapped when the lower exceeds the upper) as
// lo + ((x - lo) mod (hi - lo + 1)) and returned, and stored back only when
// write_back is set. A divide by zero returns the wrapped zero with
// zero_divisor high. One request is worked at a time through the single
// bit-serial restoring divider, which for a divide by a non-zero operand
// first forms the quotient in DATA_WIDTH steps and then, for every
// request, forms the modulo by the span in 2*DATA_WIDTH steps. The result
// sits in an output register, so the next request beat is taken while a
// finished result waits; only when the previous result is still untaken at
// completion does the block hold.
// Bounds live at byte addresses 0 and 4; write them only while idle.
module wrapping_range_arithmetic #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   req_type,
  input  logic signed [DATA_WIDTH-1:0] operand,
  input  logic                         write_back,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] result,
  output logic                         zero_divisor,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import wra_pkg::*;

  logic signed [DATA_WIDTH-1:0] min_bound;
  logic signed [DATA_WIDTH-1:0] max_bound;
  logic                         cfg_write;
  cmd_t                         cmd;
  status_t                      status;

  // Zero-wait port: every access completes in its access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Decode on the word address bit; byte offsets are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_bound <= '0;
      max_bound <= DATA_WIDTH'(255);
    end else if (cfg_write) begin
      if (paddr[2] == REG_MIN_BOUND) begin
        min_bound <= pwdata[DATA_WIDTH-1:0];
      end else begin
        max_bound <= pwdata[DATA_WIDTH-1:0];
      end
    end
  end

  // Read back sign-extended to the bus width.
  assign prdata = (paddr[2] == REG_MAX_BOUND) ? 32'(max_bound) : 32'(min_bound);

  wra_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wra_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req_type     (req_type),
    .operand      (operand),
    .write_back   (write_back),
    .min_bound    (min_bound),
    .max_bound    (max_bound),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .result       (result),
    .zero_divisor (zero_divisor)
  );

endmodule

### src/wra_checker.sv
// Port-level checks for the wrapping range arithmetic block, bound to the top.
// Depends on wrapping_range_arithmetic_macros.svh for the assertion macros.
`include "wrapping_range_arithmetic_macros.svh"

module wra_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] result,
  input logic                         zero_divisor
);

  // Hold a stalled result beat unchanged.
  `WRA_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(result) && $stable(zero_divisor), "result beat changed while stalled")

  // Drop ready once a request beat is taken: one request at a time.
  `WRA_CHECK(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "request accepted while busy")

  // A result never appears in the cycle after a request is taken.
  `WRA_CHECK(a_no_early_result, in_valid && in_ready |=> !$rose(out_valid), "result appeared too early")

endmodule

bind wrapping_range_arithmetic wra_checker #(.DATA_WIDTH(DATA_WIDTH)) u_wra_checker (.*);
